// ----- hdl/lusm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lusm_pkg
// Shared types and codes for the small-matrix LU solver.
// ----------------------------------------------------------------------------
package lusm_pkg;

  localparam int ORDER_DEF         = 3;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
  localparam logic [1:0] CMD_SOLVE       = 2'd2;

  localparam logic [1:0] KIND_LOWER    = 2'd0;
  localparam logic [1:0] KIND_UPPER    = 2'd1;
  localparam logic [1:0] KIND_FORWARD  = 2'd2;
  localparam logic [1:0] KIND_SOLUTION = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         row;
    logic [1:0]         column;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         out_row;
    logic [1:0]         out_column;
    logic signed [31:0] out_value;
    logic               singular;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BASE, ST_BASE_CAP, ST_TERM, ST_MUL, ST_ACC, ST_SUB, ST_DIV, ST_DIVW, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_LU, PH_Y, PH_X} phase_t;

endpackage
`default_nettype wire

// ----- hdl/lu_solve_small_matrix_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lu_solve_small_matrix_top
// Doolittle LU factorization and triangular solve in signed fixed point.
// ----------------------------------------------------------------------------
// Loads (matrix or right-hand entry) are accepted back to back and never raise busy.
// A solve raises busy, walks all operands through one dual-read memory with a
// shared multiplier/accumulator and a radix-2 divider, then strobes
// 2*ORDER*ORDER+2*ORDER results on consecutive cycles: L, U, y, x, with last
// on the final one. Each dot-product term passes through the TERM, MUL and ACC
// states; a zero divisor skips the divider and saturates. Results cannot be
// stalled: out_valid is a one-cycle strobe per transfer.
module lu_solve_small_matrix_top #(
  parameter int ORDER         = lusm_pkg::ORDER_DEF,
  parameter int FRACTION_BITS = lusm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lusm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output lusm_pkg::out_item_t      out_item
);
  import lusm_pkg::*;

  localparam int NN     = ORDER * ORDER;
  localparam int B_BASE = NN;
  localparam int L_BASE = NN + ORDER;
  localparam int U_BASE = 2 * NN + ORDER;
  localparam int Y_BASE = 3 * NN + ORDER;
  localparam int X_BASE = 3 * NN + 2 * ORDER;
  localparam int DEPTH  = 3 * NN + 3 * ORDER;
  localparam int AW     = $clog2(DEPTH);
  localparam int IW     = $clog2(ORDER);
  localparam int CW     = $clog2(ORDER + 1);
  localparam int NW     = 32 + FRACTION_BITS;
  localparam int DCW    = $clog2(NW + 1);

  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRACTION_BITS;

  function automatic logic [AW-1:0] addr_of(input int base, input logic [IW-1:0] r,
                                            input logic [IW-1:0] c);
    addr_of = AW'(base) + AW'(r) * AW'(ORDER) + AW'(c);
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7fff_ffff)       sat33 = MAXV;
    else if (v < -33'sh0_8000_0000) sat33 = MINV;
    else                            sat33 = v[31:0];
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff)       sat64 = MAXV;
    else if (v < -64'sh8000_0000) sat64 = MINV;
    else                          sat64 = v[31:0];
  endfunction

  // storage
  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [31:0]      rd0_q, rd1_q;
  logic             rd0_ok_q, rd1_ok_q;
  logic signed [31:0] rd0, rd1;
  logic             we;
  logic [AW-1:0]    wa, ra0, ra1;
  logic [31:0]      wd;

  // control
  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            sing_r, sing_nxt;
  logic [1:0]      ek_r, ek_nxt;
  logic [IW-1:0]   er_r, er_nxt, ec_r, ec_nxt;
  logic            ov_r, ov_nxt;

  // datapath
  logic signed [31:0] base_r, dv_r, acc_r;
  logic signed [63:0] prod_r;
  logic [NW-1:0]      dq_r;
  logic [32:0]        drem_r;
  logic [31:0]        dd_r;
  logic               dneg_r;
  logic [DCW-1:0]     dcnt_r;
  logic [1:0]         okind_r;
  logic [IW-1:0]      orow_r, ocol_r;
  logic               oone_r, olast_r;

  assign rd0 = rd0_ok_q ? $signed(rd0_q) : 32'sd0;
  assign rd1 = rd1_ok_q ? $signed(rd1_q) : 32'sd0;

  logic [AW-1:0]      base_a, dva_a, t0_a, t1_a, dst_a, emit_a;
  logic [CW-1:0]      kstart, kend;
  logic               use_div, adv, emit_last;
  logic signed [31:0] prodq, diff, divres;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [31:0]        nmag, dmag;

  always_comb begin
    base_a  = addr_of(0, i_r, j_r);
    dva_a   = addr_of(U_BASE, j_r, j_r);
    t0_a    = addr_of(L_BASE, i_r, k_r[IW-1:0]);
    t1_a    = addr_of(U_BASE, k_r[IW-1:0], j_r);
    dst_a   = addr_of(U_BASE, i_r, j_r);
    kstart  = '0;
    kend    = CW'(i_r);
    use_div = 1'b0;
    unique case (phase_r)
      PH_LU: begin
        if (i_r > j_r) begin
          kend    = CW'(j_r);
          dst_a   = addr_of(L_BASE, i_r, j_r);
          use_div = 1'b1;
        end
      end
      PH_Y: begin
        base_a = addr_of(B_BASE, '0, i_r);
        t1_a   = addr_of(Y_BASE, '0, k_r[IW-1:0]);
        dst_a  = addr_of(Y_BASE, '0, i_r);
      end
      PH_X: begin
        base_a  = addr_of(Y_BASE, '0, i_r);
        dva_a   = addr_of(U_BASE, i_r, i_r);
        t0_a    = addr_of(U_BASE, i_r, k_r[IW-1:0]);
        t1_a    = addr_of(X_BASE, '0, k_r[IW-1:0]);
        dst_a   = addr_of(X_BASE, '0, i_r);
        kstart  = CW'(i_r) + CW'(1);
        kend    = CW'(ORDER);
        use_div = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ek_r)
      KIND_LOWER:   emit_a = addr_of(L_BASE, er_r, ec_r);
      KIND_UPPER:   emit_a = addr_of(U_BASE, er_r, ec_r);
      KIND_FORWARD: emit_a = addr_of(Y_BASE, '0, er_r);
      default:      emit_a = addr_of(X_BASE, '0, er_r);
    endcase
    emit_last = (ek_r == KIND_SOLUTION) && (er_r == IW'(ORDER - 1));
  end

  always_comb begin
    prodq  = sat64(prod_r >>> FRACTION_BITS);
    diff   = sat33({base_r[31], base_r} - {acc_r[31], acc_r});
    nmag   = diff[31] ? 32'(-{diff[31], diff}) : 32'(diff);
    dmag   = dv_r[31] ? 32'(-{dv_r[31], dv_r}) : 32'(dv_r);
    rem_sh = {drem_r[31:0], dq_r[NW-1]};
    ge     = rem_sh >= {1'b0, dd_r};
    if (dneg_r) begin
      divres = (dq_r > NW'(33'h0_8000_0000)) ? MINV : 32'(-dq_r);
    end else begin
      divres = (dq_r > NW'(33'h0_7fff_ffff)) ? MAXV : 32'(dq_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    sing_nxt  = sing_r;
    ek_nxt    = ek_r;
    er_nxt    = er_r;
    ec_nxt    = ec_r;
    ov_nxt    = 1'b0;
    we        = 1'b0;
    wa        = dst_a;
    wd        = 32'(diff);
    adv       = 1'b0;
    ra0       = t0_a;
    ra1       = t1_a;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          case (in_item.command)
            CMD_LOAD_MATRIX: begin
              we = (32'(in_item.row) < ORDER) && (32'(in_item.column) < ORDER);
              wa = addr_of(0, in_item.row[IW-1:0], in_item.column[IW-1:0]);
              wd = in_item.value;
            end
            CMD_LOAD_RHS: begin
              we = 32'(in_item.row) < ORDER;
              wa = addr_of(B_BASE, '0, in_item.row[IW-1:0]);
              wd = in_item.value;
            end
            CMD_SOLVE: begin
              state_nxt = ST_BASE;
              phase_nxt = PH_LU;
              i_nxt     = '0;
              j_nxt     = '0;
              sing_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_BASE: begin
        ra0       = base_a;
        ra1       = dva_a;
        k_nxt     = kstart;
        state_nxt = ST_BASE_CAP;
      end
      ST_BASE_CAP: state_nxt = (k_r != kend) ? ST_TERM : ST_SUB;
      ST_TERM:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_ACC;
      ST_ACC: begin
        k_nxt     = k_r + CW'(1);
        state_nxt = (k_r + CW'(1) != kend) ? ST_TERM : ST_SUB;
      end
      ST_SUB: begin
        if (!use_div) begin
          we  = 1'b1;
          adv = 1'b1;
        end else if (dv_r == 32'sd0) begin
          we       = 1'b1;
          wd       = diff[31] ? MINV : MAXV;
          sing_nxt = 1'b1;
          adv      = 1'b1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  if (dcnt_r == DCW'(1)) state_nxt = ST_DIVW;
      ST_DIVW: begin
        we  = 1'b1;
        wd  = divres;
        adv = 1'b1;
      end
      ST_EMIT: begin
        ra0    = emit_a;
        ov_nxt = 1'b1;
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end else if (ek_r == KIND_FORWARD || ek_r == KIND_SOLUTION) begin
          if (er_r == IW'(ORDER - 1)) begin
            er_nxt = '0;
            ek_nxt = ek_r + 2'd1;
          end else begin
            er_nxt = er_r + IW'(1);
          end
        end else if (ec_r == IW'(ORDER - 1)) begin
          ec_nxt = '0;
          if (er_r == IW'(ORDER - 1)) begin
            er_nxt = '0;
            ek_nxt = ek_r + 2'd1;
          end else begin
            er_nxt = er_r + IW'(1);
          end
        end else begin
          ec_nxt = ec_r + IW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (adv) begin
      state_nxt = ST_BASE;
      unique case (phase_r)
        PH_LU: begin
          if (j_r == IW'(ORDER - 1)) begin
            j_nxt = '0;
            if (i_r == IW'(ORDER - 1)) begin
              i_nxt     = '0;
              phase_nxt = PH_Y;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end
        PH_Y: begin
          if (i_r == IW'(ORDER - 1)) begin
            phase_nxt = PH_X;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
        default: begin
          if (i_r == '0) begin
            state_nxt = ST_EMIT;
            ek_nxt    = KIND_LOWER;
            er_nxt    = '0;
            ec_nxt    = '0;
          end else begin
            i_nxt = i_r - IW'(1);
          end
        end
      endcase
    end

    vld_nxt = vld_r;
    if (we) vld_nxt[wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_LU;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      sing_r  <= 1'b0;
      ek_r    <= KIND_LOWER;
      er_r    <= '0;
      ec_r    <= '0;
      ov_r    <= 1'b0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      sing_r  <= sing_nxt;
      ek_r    <= ek_nxt;
      er_r    <= er_nxt;
      ec_r    <= ec_nxt;
      ov_r    <= ov_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0_q    <= mem[ra0];
    rd1_q    <= mem[ra1];
    rd0_ok_q <= vld_r[ra0];
    rd1_ok_q <= vld_r[ra1];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_BASE) acc_r <= 32'sd0;
    if (state_r == ST_BASE_CAP) begin
      base_r <= rd0;
      dv_r   <= rd1;
    end
    if (state_r == ST_MUL) prod_r <= rd0 * rd1;
    if (state_r == ST_ACC) acc_r <= sat33({acc_r[31], acc_r} + {prodq[31], prodq});
    if (state_r == ST_SUB) begin
      dq_r   <= {nmag, {FRACTION_BITS{1'b0}}};
      drem_r <= '0;
      dd_r   <= dmag;
      dneg_r <= diff[31] ^ dv_r[31];
      dcnt_r <= DCW'(NW);
    end
    if (state_r == ST_DIV) begin
      drem_r <= ge ? rem_sh - {1'b0, dd_r} : rem_sh;
      dq_r   <= {dq_r[NW-2:0], ge};
      dcnt_r <= dcnt_r - DCW'(1);
    end
    if (state_r == ST_EMIT) begin
      okind_r <= ek_r;
      orow_r  <= er_r;
      ocol_r  <= (ek_r == KIND_FORWARD || ek_r == KIND_SOLUTION) ? '0 : ec_r;
      oone_r  <= (ek_r == KIND_LOWER) && (er_r == ec_r);
      olast_r <= emit_last;
    end
  end

  assign busy      = (state_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  always_comb begin
    out_item.kind       = okind_r;
    out_item.out_row    = 2'(orow_r);
    out_item.out_column = 2'(ocol_r);
    out_item.out_value  = oone_r ? ONE : rd0;
    out_item.singular   = sing_r;
    out_item.last       = olast_r;
  end

  // a run ends after its last transfer
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result after last");

  // results of a run come back to back
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("gap in result burst");

  // a solve command always raises busy
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.command == CMD_SOLVE |=> busy)
    else $error("solve not started");

  // divider only runs on a nonzero divisor
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dd_r != 32'd0)
    else $error("divide by zero reached divider");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the small-matrix LU solver: loads A and b, issues
// solve commands, predicts L, U, y, x in fixed point and checks each transfer.
// ----------------------------------------------------------------------------
module testbench;
  import lusm_pkg::*;

  localparam int N  = ORDER_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  lu_solve_small_matrix_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 11;
  bit driver_done = 1'b0;

  logic signed [31:0] mat_a[N*N], rhs[N], lo[N*N], up[N*N], fy[N], sx[N];

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return MAXV;
    if (v < -66'sd2147483648) return MINV;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] p;
    p = a * b;
    return sat(p >>> FB);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] s;
    s = a;
    s = s + b;
    return sat(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] s;
    s = a;
    s = s - b;
    return sat(s);
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
                                               input logic signed [31:0] d,
                                               inout bit sing);
    logic signed [65:0] num, den;
    if (d == 0) begin
      sing = 1'b1;
      return (n >= 0) ? MAXV : MINV;
    end
    num = n;
    num = num <<< FB;
    den = d;
    return sat(num / den);
  endfunction

  task automatic predict_solve();
    bit sing;
    logic signed [31:0] acc;
    out_item_t r;
    sing = 1'b0;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        acc = 0;
        if (i <= j) begin
          for (int k = 0; k < i; k++) acc = qadd(acc, qmul(lo[i*N+k], up[k*N+j]));
          up[i*N+j] = qsub(mat_a[i*N+j], acc);
          lo[i*N+j] = (i == j) ? (32'sd1 <<< FB) : 32'sd0;
        end else begin
          up[i*N+j] = 0;
          for (int k = 0; k < j; k++) acc = qadd(acc, qmul(lo[i*N+k], up[k*N+j]));
          lo[i*N+j] = qdiv(qsub(mat_a[i*N+j], acc), up[j*N+j], sing);
        end
      end
    for (int i = 0; i < N; i++) begin
      acc = 0;
      for (int j = 0; j < i; j++) acc = qadd(acc, qmul(lo[i*N+j], fy[j]));
      fy[i] = qsub(rhs[i], acc);
    end
    for (int i = N - 1; i >= 0; i--) begin
      acc = 0;
      for (int j = i + 1; j < N; j++) acc = qadd(acc, qmul(up[i*N+j], sx[j]));
      sx[i] = qdiv(qsub(fy[i], acc), up[i*N+i], sing);
    end
    for (int t = 0; t < 2*N*N + 2*N; t++) begin
      r = '0;
      if (t < N*N) begin
        r.kind = KIND_LOWER; r.out_row = 2'(t / N); r.out_column = 2'(t % N);
        r.out_value = lo[t];
      end else if (t < 2*N*N) begin
        r.kind = KIND_UPPER; r.out_row = 2'((t-N*N) / N); r.out_column = 2'((t-N*N) % N);
        r.out_value = up[t-N*N];
      end else if (t < 2*N*N + N) begin
        r.kind = KIND_FORWARD; r.out_row = 2'(t - 2*N*N); r.out_value = fy[t-2*N*N];
      end else begin
        r.kind = KIND_SOLUTION; r.out_row = 2'(t - 2*N*N - N); r.out_value = sx[t-2*N*N-N];
      end
      r.singular = sing;
      r.last = (t == 2*N*N + 2*N - 1);
      expected_results.push_back(r);
    end
  endtask

  // accepted-command model update
  task automatic apply_cmd(input in_item_t c);
    case (c.command)
      CMD_LOAD_MATRIX: if (c.row < N && c.column < N) mat_a[c.row*N+c.column] = c.value;
      CMD_LOAD_RHS:    if (c.row < N) rhs[c.row] = c.value;
      CMD_SOLVE:       predict_solve();
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) apply_cmd(in_item);
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
          if (pending_cmds.size() == 0) driver_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transfer: %p", out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_item.kind); errors++;
        end
        if (out_item.out_row !== e.out_row) begin
          $error("out_row exp %0d got %0d", e.out_row, out_item.out_row); errors++;
        end
        if (out_item.out_column !== e.out_column) begin
          $error("out_column exp %0d got %0d", e.out_column, out_item.out_column); errors++;
        end
        if (out_item.out_value !== e.out_value) begin
          $error("out_value exp %h got %h", e.out_value, out_item.out_value); errors++;
        end
        if (out_item.singular !== e.singular) begin
          $error("singular exp %0d got %0d", e.singular, out_item.singular); errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item.last); errors++;
        end
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] c, input logic [1:0] r,
                                  input logic [1:0] col, input logic [31:0] v);
    in_item_t t;
    t.command = c; t.row = r; t.column = col; t.value = v;
    return t;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return MAXV;
      2: return MINV;
      3: return 32'($signed($urandom_range(8, 0)) - 4) <<< FB;
      default: return 32'($signed($urandom_range(131072)) - 65536) <<< $urandom_range(6);
    endcase
  endfunction

  task automatic wait_drained();
    driver_done = 1'b0;
    while (!driver_done || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        pending_cmds.push_back(mk(2'($urandom_range(3)), 2'($urandom_range(3)),
                                  2'($urandom_range(3)), $urandom()));
      end else begin
        for (int i = 0; i < N; i++)
          for (int j = 0; j < N; j++)
            if ($urandom_range(2) != 0)
              pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 2'(i), 2'(j), rand_value()));
        for (int i = 0; i < N; i++)
          if ($urandom_range(2) != 0)
            pending_cmds.push_back(mk(CMD_LOAD_RHS, 2'(i), 2'($urandom_range(3)),
                                      rand_value()));
        pending_cmds.push_back(mk(CMD_SOLVE, 2'($urandom_range(3)), 2'($urandom_range(3)),
                                  $urandom()));
        n += N*N;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < N*N; i++) begin
      mat_a[i] = 0; lo[i] = 0; up[i] = 0;
    end
    for (int i = 0; i < N; i++) begin
      rhs[i] = 0; fy[i] = 0; sx[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero matrix solve (singular), identity, extremes, ignored items
    pending_cmds.push_back(mk(CMD_SOLVE, 0, 0, 0));
    for (int i = 0; i < N; i++) begin
      pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 2'(i), 2'(i), 32'sd1 <<< FB));
      pending_cmds.push_back(mk(CMD_LOAD_RHS, 2'(i), 0, (i == 0) ? MAXV : MINV));
    end
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 3, 0, MAXV));
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 0, 3, MAXV));
    pending_cmds.push_back(mk(CMD_LOAD_RHS, 3, 3, MAXV));
    pending_cmds.push_back(mk(CMD_UNUSED, 3, 3, 32'hffffffff));
    pending_cmds.push_back(mk(CMD_SOLVE, 3, 3, 32'hffffffff));
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 0, 0, 32'sd1));
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 1, 0, MAXV));
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 2, 2, MINV));
    pending_cmds.push_back(mk(CMD_LOAD_MATRIX, 1, 2, MINV));
    pending_cmds.push_back(mk(CMD_SOLVE, 0, 0, 0));
    wait_drained();

    send_idle_pct = 11;
    random_phase(110);
    wait_drained();
    send_idle_pct = 72;
    random_phase(110);
    wait_drained();
    send_idle_pct = 0;
    random_phase(110);
    wait_drained();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- lu_solve_small_matrix_top.f -----
hdl/lusm_pkg.sv
hdl/lu_solve_small_matrix_top.sv
tb/sv/testbench.sv
